[src/hsfo_pkg.sv]
// hsfo_pkg: shared types and codes for the hot standby failover controller.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package hsfo_pkg;

    // Counter width: counts saturate at threshold + 1 (at most 256)
    localparam int CNT_W     = 9;
    localparam int THR_W     = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 8;

    // Event function codes
    localparam logic [1:0] FUNC_HEARTBEAT  = 2'd0;
    localparam logic [1:0] FUNC_SWITCH     = 2'd1;
    localparam logic [1:0] FUNC_PERIOD_END = 2'd2;

    // Control codes
    localparam logic [1:0] CODE_NONE    = 2'd0;
    localparam logic [1:0] CODE_ACTIVE  = 2'd1;
    localparam logic [1:0] CODE_STANDBY = 2'd2;
    localparam logic [1:0] CODE_ACK     = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MISS_THRESHOLD  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NODE_IS_PRIMARY = 1'd1;

    typedef struct packed {
        logic [1:0] func;
        logic [1:0] ctrl_code;
        logic       peer_active;
    } hsfo_evt_t;

    typedef struct packed {
        logic       node_active;
        logic [1:0] send_ctrl;
    } hsfo_res_t;

    typedef struct packed {
        logic [THR_W-1:0] miss_threshold;
        logic             node_is_primary;
    } hsfo_cfg_t;

    typedef struct packed {
        logic             role_active;
        logic [1:0]       pending_command;
        logic [1:0]       queued_send;
        logic [CNT_W-1:0] miss_count;
        logic [CNT_W-1:0] command_age;
        logic             heard_from_peer;
    } hsfo_state_t;

endpackage

[src/hsfo_cfg.sv]
// hsfo_cfg: configuration register file (miss threshold, primary flag).
// Depends on hsfo_pkg.
`timescale 1ns / 1ps

module hsfo_cfg
    import hsfo_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    output hsfo_cfg_t            cfg
);

    hsfo_cfg_t cfg_reg;

    // Writes are taken whenever valid, so the port never pushes back
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MISS_THRESHOLD:  cfg_reg.miss_threshold  <= cfg_data[THR_W-1:0];
                REG_NODE_IS_PRIMARY: cfg_reg.node_is_primary <= cfg_data[0];
            endcase
        end
    end

endmodule

[src/hsfo_core.sv]
// hsfo_core: next-state and result logic for one event.
// Depends on hsfo_pkg; purely combinational.
`timescale 1ns / 1ps

module hsfo_core
    import hsfo_pkg::*;
(
    input  hsfo_state_t state,
    input  hsfo_cfg_t   cfg,
    input  hsfo_evt_t   evt,
    output hsfo_state_t state_next,
    output logic        res_vld,
    output hsfo_res_t   res
);

    // Saturating count: stop at threshold + 1
    function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] cnt,
                                                  input logic [THR_W-1:0] thr);
        logic [CNT_W-1:0] lim;
        logic [CNT_W:0]   n;
        lim = {1'b0, thr} + CNT_W'(1);
        n   = {1'b0, cnt} + (CNT_W+1)'(1);
        return (n > {1'b0, lim}) ? lim : n[CNT_W-1:0];
    endfunction

    logic [1:0]       resend;
    logic [CNT_W-1:0] thr_ext;

    assign resend  = (state.pending_command == CODE_ACTIVE) ? CODE_STANDBY : CODE_ACTIVE;
    assign thr_ext = {1'b0, cfg.miss_threshold};

    always_comb
    begin
        state_next = state;
        res_vld    = 1'b0;
        res        = '0;
        case (evt.func)
            FUNC_SWITCH:
            begin
                if (evt.ctrl_code == CODE_ACTIVE && !state.role_active)
                begin
                    state_next.pending_command = CODE_ACTIVE;
                    state_next.queued_send     = CODE_STANDBY;
                end
                else if (evt.ctrl_code == CODE_STANDBY && state.role_active)
                begin
                    state_next.role_active     = 1'b0;
                    state_next.pending_command = CODE_STANDBY;
                    state_next.queued_send     = CODE_ACTIVE;
                end
                if (evt.ctrl_code != CODE_NONE)
                    state_next.command_age = '0;
            end
            FUNC_HEARTBEAT:
            begin
                state_next.miss_count      = '0;
                state_next.heard_from_peer = 1'b1;
                case (evt.ctrl_code)
                    CODE_ACK:
                    begin
                        if (state.pending_command == CODE_ACTIVE)
                            state_next.role_active = 1'b1;
                        state_next.pending_command = CODE_NONE;
                        state_next.queued_send     = CODE_NONE;
                        state_next.command_age     = '0;
                    end
                    CODE_ACTIVE, CODE_STANDBY:
                    begin
                        state_next.role_active = (evt.ctrl_code == CODE_ACTIVE);
                        state_next.queued_send = CODE_ACK;
                    end
                    default:
                    begin
                        // No code: resolve a role conflict, or repeat the command
                        if (state.pending_command == CODE_NONE)
                        begin
                            if (evt.peer_active == state.role_active)
                                state_next.role_active = cfg.node_is_primary;
                        end
                        else
                        begin
                            state_next.queued_send = resend;
                        end
                    end
                endcase
            end
            FUNC_PERIOD_END:
            begin
                if (!state.heard_from_peer)
                begin
                    state_next.miss_count = count_up(state.miss_count, cfg.miss_threshold);
                    if (state_next.miss_count > thr_ext)
                        state_next.role_active = 1'b1;
                    if (state.pending_command != CODE_NONE)
                    begin
                        state_next.command_age = count_up(state.command_age,
                                                          cfg.miss_threshold);
                        if (state_next.command_age > thr_ext)
                        begin
                            state_next.pending_command = CODE_NONE;
                            state_next.role_active     = 1'b1;
                        end
                        else
                        begin
                            state_next.queued_send = resend;
                        end
                    end
                end
                res_vld         = 1'b1;
                res.node_active = state_next.role_active;
                res.send_ctrl   = state_next.queued_send;
                state_next.queued_send     = CODE_NONE;
                state_next.heard_from_peer = 1'b0;
            end
            default:
            begin
                // Unused function code: drop the event
            end
        endcase
    end

endmodule

[src/hot_standby_failover_controller.sv]
// Hot standby failover controller: one node of a redundant pair.
// A period-end transaction is registered in the event register at acceptance; its result
// is then registered in the result register, from which it can be taken.
// Throughput: one event transaction per clock; the event register stalls only while
// a result is held by a stalled result register and the registered event makes one too.
// Reset (rst_n, async, active low): standby role, no command, counters and config zero.
`timescale 1ns / 1ps

module hot_standby_failover_controller
    import hsfo_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // event channel
    input  logic                 evt_valid,
    output logic                 evt_stall,
    input  hsfo_evt_t            evt,
    // result channel
    output logic                 res_valid,
    input  logic                 res_stall,
    output hsfo_res_t            res,
    // configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    hsfo_cfg_t   cfg;
    hsfo_state_t state_reg;
    hsfo_state_t state_next;
    hsfo_evt_t   evt_reg;
    logic        evt_vld_reg;
    hsfo_res_t   res_reg;
    logic        res_vld_reg;
    logic        core_res_vld;
    hsfo_res_t   core_res;
    logic        proceed;
    logic        do_step;

    hsfo_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    hsfo_core u_core (
        .state      (state_reg),
        .cfg        (cfg),
        .evt        (evt_reg),
        .state_next (state_next),
        .res_vld    (core_res_vld),
        .res        (core_res)
    );

    // The registered event may retire when it makes no result, or when the
    // result register is empty or being drained this cycle.
    assign proceed   = !res_vld_reg || !res_stall || !core_res_vld;
    assign do_step   = evt_vld_reg && proceed;
    assign evt_stall = evt_vld_reg && !proceed;

    // Event register: load a new transaction whenever the held one moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            evt_vld_reg <= 1'b0;
        else if (!evt_stall)
            evt_vld_reg <= evt_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!evt_stall)
            evt_reg <= evt;
    end

    // Node state: advance once per retired event
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (do_step)
            state_reg <= state_next;
    end

    // Result register: fill on a period end, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_vld_reg <= 1'b0;
        else if (do_step && core_res_vld)
            res_vld_reg <= 1'b1;
        else if (!res_stall)
            res_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (do_step && core_res_vld)
            res_reg <= core_res;
    end

    assign res_valid = res_vld_reg;
    assign res       = res_reg;

endmodule

[src/hsfo_checker.sv]
// hsfo_checker: port-level assertions for the failover controller, bound to the top.
// Depends on hsfo_pkg and hot_standby_failover_controller.
`timescale 1ns / 1ps

module hsfo_checker
    import hsfo_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 evt_valid,
    input logic                 evt_stall,
    input hsfo_evt_t            evt,
    input logic                 res_valid,
    input logic                 res_stall,
    input hsfo_res_t            res
);

    // A stalled result transaction holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("result changed while stalled");

    // A fresh result comes only from an accepted period end, carried through the event and result registers
    a_res_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |->
            $past(evt_valid && !evt_stall && evt.func == FUNC_PERIOD_END, 2))
        else $error("result without a period-end event");

    // With the result side empty the event side never stalls
    a_no_stall_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> !evt_stall)
        else $error("event stalled while result register empty");

endmodule

bind hot_standby_failover_controller hsfo_checker u_hsfo_checker (.*);

[tb/sv/hot_standby_failover_controller_tb.sv]
// Self-checking testbench for hot_standby_failover_controller: directed table, then random
// event traffic under several idle/stall mixes, checked against an in-bench role predictor.
// Depends on hsfo_pkg and the controller RTL only.
`timescale 1ns / 1ps

module hot_standby_failover_controller_tb;
    import hsfo_pkg::*;

    // func value the block must ignore (no result, no state change)
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int PHASE_ITEMS   = 400;
    localparam int HOLD_CYCLES   = 300;
    localparam int PRESSURE_ITEMS = 40;

    typedef enum bit {ROW_EVENT, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t              kind;
        hsfo_evt_t              ev;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DAT_W-1:0]   data;
        bit                     typed;  // expected status given in the row itself
        hsfo_res_t              status;
    } stim_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 evt_valid;
    logic                 evt_stall;
    hsfo_evt_t            evt;
    logic                 res_valid;
    logic                 res_stall;
    hsfo_res_t            res;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    // Predictor copy of the node: role, command bookkeeping, counters, registers
    logic             m_role;
    logic [1:0]       m_pend;
    logic [1:0]       m_queued;
    logic [CNT_W-1:0] m_miss;
    logic [CNT_W-1:0] m_age;
    logic             m_heard;
    logic [THR_W-1:0] m_thr;
    logic             m_primary;

    hsfo_res_t expected_status_q[$];
    stim_row_t directed_rows[$];

    int errors        = 0;
    int events_sent   = 0;
    int statuses_seen = 0;
    int reg_writes    = 0;
    int cycle_cnt     = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    bit hold_req      = 1'b0;
    bit hold_done     = 1'b0;
    int hold_cnt      = 0;

    hot_standby_failover_controller i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt       (evt),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog: end the run if the traffic never drains
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d statuses still outstanding",
                     cycle_cnt, expected_status_q.size());
            $display("simulation failed");
            $finish;
        end
    end

    // Counter saturates at threshold + 1; a lowered threshold pulls it down at the next count
    function automatic logic [CNT_W-1:0] sat_count(input logic [CNT_W-1:0] c);
        logic [CNT_W:0] lim;
        logic [CNT_W:0] n;
        lim = (CNT_W+1)'(m_thr) + 1'b1;
        n   = (CNT_W+1)'(c) + 1'b1;
        return (n > lim) ? lim[CNT_W-1:0] : n[CNT_W-1:0];
    endfunction

    // Code to send again for a command still waiting on the peer
    function automatic logic [1:0] resent_code();
        return (m_pend == CODE_ACTIVE) ? CODE_STANDBY : CODE_ACTIVE;
    endfunction

    // Apply one accepted event to the predictor; report the status a period end emits
    task automatic predict_node_status(input hsfo_evt_t e, output bit emits,
                                       output hsfo_res_t status);
        emits  = 1'b0;
        status = '0;
        case (e.func)
            FUNC_SWITCH:
            begin
                if (e.ctrl_code == CODE_ACTIVE && !m_role)
                begin
                    m_pend   = CODE_ACTIVE;
                    m_queued = CODE_STANDBY;
                end
                else if (e.ctrl_code == CODE_STANDBY && m_role)
                begin
                    m_role   = 1'b0;
                    m_pend   = CODE_STANDBY;
                    m_queued = CODE_ACTIVE;
                end
                if (e.ctrl_code != CODE_NONE)
                    m_age = '0;
            end
            FUNC_HEARTBEAT:
            begin
                m_miss  = '0;
                m_heard = 1'b1;
                if (e.ctrl_code == CODE_ACK)
                begin
                    if (m_pend == CODE_ACTIVE)
                        m_role = 1'b1;
                    m_pend   = CODE_NONE;
                    m_queued = CODE_NONE;
                    m_age    = '0;
                end
                else if (e.ctrl_code == CODE_ACTIVE || e.ctrl_code == CODE_STANDBY)
                begin
                    m_role   = (e.ctrl_code == CODE_ACTIVE);
                    m_queued = CODE_ACK;
                end
                else if (m_pend == CODE_NONE)
                begin
                    // conflict: both report the same role, the primary takes over
                    if (e.peer_active == m_role)
                        m_role = m_primary;
                end
                else
                    m_queued = resent_code();
            end
            FUNC_PERIOD_END:
            begin
                if (!m_heard)
                begin
                    m_miss = sat_count(m_miss);
                    if (m_miss > m_thr)
                        m_role = 1'b1;
                    if (m_pend != CODE_NONE)
                    begin
                        m_age = sat_count(m_age);
                        if (m_age > m_thr)
                        begin
                            // command never acknowledged: drop it and take over
                            m_pend = CODE_NONE;
                            m_role = 1'b1;
                        end
                        else
                            m_queued = resent_code();
                    end
                end
                emits              = 1'b1;
                status.node_active = m_role;
                status.send_ctrl   = m_queued;
                m_queued           = CODE_NONE;
                m_heard            = 1'b0;
            end
            default: ;
        endcase
    endtask

    // Offer one event; hold it until accepted, then record the status it should produce.
    // Entered and left at a falling edge.
    task automatic send_event(input hsfo_evt_t e, input bit typed, input hsfo_res_t typed_status);
        bit        emits;
        hsfo_res_t status;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            evt_valid <= 1'b0;
            @(negedge clk);
        end
        evt       <= e;
        evt_valid <= 1'b1;
        @(posedge clk);
        while (evt_stall)
            @(posedge clk);
        predict_node_status(e, emits, status);
        if (emits)
            expected_status_q.insert(expected_status_q.size(), typed ? typed_status : status);
        if (e.func != FUNC_UNUSED)
            events_sent++;
        @(negedge clk);
    endtask

    task automatic send_item(input logic [1:0] f, input logic [1:0] code, input logic peer);
        hsfo_evt_t e;
        e.func        = f;
        e.ctrl_code   = code;
        e.peer_active = peer;
        send_event(e, 1'b0, '0);
    endtask

    // Drop valid and wait until every status is back, plus the pipeline latency
    task automatic settle();
        evt_valid <= 1'b0;
        while (expected_status_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // Register write transaction; the block is idle whenever this is called
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_MISS_THRESHOLD)
            m_thr = data;
        else if (idx == REG_NODE_IS_PRIMARY)
            m_primary = data[0];
        reg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    function automatic stim_row_t ev_row(input logic [1:0] f, input logic [1:0] code,
                                         input logic peer, input bit typed,
                                         input logic act, input logic [1:0] send);
        stim_row_t r;
        r.kind                 = ROW_EVENT;
        r.ev.func              = f;
        r.ev.ctrl_code         = code;
        r.ev.peer_active       = peer;
        r.idx                  = '0;
        r.data                 = '0;
        r.typed                = typed;
        r.status.node_active   = act;
        r.status.send_ctrl     = send;
        return r;
    endfunction

    function automatic stim_row_t wr_row(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DAT_W-1:0] data);
        stim_row_t r;
        r.kind   = ROW_WRITE;
        r.ev     = '0;
        r.idx    = idx;
        r.data   = data;
        r.typed  = 1'b0;
        r.status = '0;
        return r;
    endfunction

    // Append one row at the end of the directed table
    task automatic add_row(input stim_row_t r);
        directed_rows.insert(directed_rows.size(), r);
    endtask

    // Receiver stall: random per phase, with one long hold-off counted here
    initial
    begin
        res_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                res_stall <= 1'b1;
                hold_cnt++;
                if (hold_cnt == HOLD_CYCLES)
                    hold_done = 1'b1;
            end
            else
                res_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Result checker: every accepted status must match the oldest prediction
    always @(posedge clk)
    begin
        hsfo_res_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            statuses_seen++;
            if (expected_status_q.size() == 0)
            begin
                $display("%0t: unexpected status node_active=%0d send_ctrl=%0d",
                         $time, res.node_active, res.send_ctrl);
                errors++;
            end
            else
            begin
                want = expected_status_q.pop_front();
                if (res.node_active !== want.node_active)
                begin
                    $display("%0t: node_active expected %0d actual %0d",
                             $time, want.node_active, res.node_active);
                    errors++;
                end
                if (res.send_ctrl !== want.send_ctrl)
                begin
                    $display("%0t: send_ctrl expected %0d actual %0d",
                             $time, want.send_ctrl, res.send_ctrl);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int        pick;
        int        burst_max;
        int        thr_sel;
        logic [1:0] f;
        stim_row_t row;

        // Drive every input to a known value before the first edge
        rst_n     = 1'b0;
        evt_valid = 1'b0;
        evt       = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;

        m_role    = 1'b0;
        m_pend    = CODE_NONE;
        m_queued  = CODE_NONE;
        m_miss    = '0;
        m_age     = '0;
        m_heard   = 1'b0;
        m_thr     = '0;
        m_primary = 1'b0;

        // Directed table. Typed rows carry a status obvious from the spec; the rest use
        // the predictor.
        // After reset the threshold is zero: a silent period forces the node active
        add_row(ev_row(FUNC_PERIOD_END, CODE_NONE, 1'b0, 1'b1, 1'b1, CODE_NONE));
        // same-role conflict, secondary node yields
        add_row(ev_row(FUNC_HEARTBEAT, CODE_NONE, 1'b1, 1'b0, 1'b0, CODE_NONE));
        add_row(ev_row(FUNC_PERIOD_END, CODE_NONE, 1'b0, 1'b1, 1'b0, CODE_NONE));
        add_row(wr_row(REG_MISS_THRESHOLD, 8'd3));
        add_row(wr_row(REG_NODE_IS_PRIMARY, 8'd1));
        // local go-active waits for the acknowledge; resend while it is pending
        add_row(ev_row(FUNC_SWITCH, CODE_ACTIVE, 1'b0, 1'b0, 1'b0, CODE_NONE));
        add_row(ev_row(FUNC_PERIOD_END, CODE_NONE, 1'b0, 1'b0, 1'b0, CODE_NONE));
        add_row(ev_row(FUNC_HEARTBEAT, CODE_ACK, 1'b0, 1'b0, 1'b0, CODE_NONE));
        add_row(ev_row(FUNC_PERIOD_END, CODE_NONE, 1'b1, 1'b0, 1'b0, CODE_NONE));
        // peer orders standby, then active; the standby order is acknowledged
        add_row(ev_row(FUNC_HEARTBEAT, CODE_STANDBY, 1'b1, 1'b0, 1'b0, CODE_NONE));
        add_row(ev_row(FUNC_PERIOD_END, CODE_ACK, 1'b0, 1'b1, 1'b0, CODE_ACK));
        add_row(ev_row(FUNC_HEARTBEAT, CODE_ACTIVE, 1'b0, 1'b0, 1'b0, CODE_NONE));
        // local go-standby takes effect at once; no-code heartbeat resends the command
        add_row(ev_row(FUNC_SWITCH, CODE_STANDBY, 1'b0, 1'b0, 1'b0, CODE_NONE));
        add_row(ev_row(FUNC_HEARTBEAT, CODE_NONE, 1'b0, 1'b0, 1'b0, CODE_NONE));
        // acknowledge code as a local request only clears the command age
        add_row(ev_row(FUNC_SWITCH, CODE_ACK, 1'b1, 1'b0, 1'b0, CODE_NONE));
        add_row(ev_row(FUNC_SWITCH, CODE_NONE, 1'b0, 1'b0, 1'b0, CODE_NONE));
        // unused func: ignored, no status
        add_row(ev_row(FUNC_UNUSED, CODE_ACK, 1'b1, 1'b0, 1'b0, CODE_NONE));
        add_row(ev_row(FUNC_PERIOD_END, CODE_NONE, 1'b0, 1'b0, 1'b0, CODE_NONE));
        // peer goes silent: command ages out on the fourth period and the node takes over
        add_row(ev_row(FUNC_PERIOD_END, CODE_NONE, 1'b0, 1'b0, 1'b0, CODE_NONE));
        add_row(ev_row(FUNC_PERIOD_END, CODE_NONE, 1'b0, 1'b0, 1'b0, CODE_NONE));
        add_row(ev_row(FUNC_PERIOD_END, CODE_NONE, 1'b0, 1'b0, 1'b0, CODE_NONE));
        add_row(ev_row(FUNC_PERIOD_END, CODE_NONE, 1'b0, 1'b1, 1'b1, CODE_NONE));
        // conflict with both active, primary node keeps the role
        add_row(ev_row(FUNC_HEARTBEAT, CODE_NONE, 1'b1, 1'b0, 1'b0, CODE_NONE));
        add_row(wr_row(REG_MISS_THRESHOLD, 8'd255));
        add_row(wr_row(REG_NODE_IS_PRIMARY, 8'd0));
        add_row(ev_row(FUNC_HEARTBEAT, CODE_NONE, 1'b1, 1'b0, 1'b0, CODE_NONE));
        add_row(ev_row(FUNC_PERIOD_END, CODE_NONE, 1'b0, 1'b1, 1'b0, CODE_NONE));
        // two silent periods: miss count reaches two, still below the threshold
        add_row(ev_row(FUNC_PERIOD_END, CODE_NONE, 1'b0, 1'b1, 1'b0, CODE_NONE));
        add_row(ev_row(FUNC_PERIOD_END, CODE_NONE, 1'b0, 1'b1, 1'b0, CODE_NONE));
        // threshold lowered below the miss count: the count drops to threshold + 1
        add_row(wr_row(REG_MISS_THRESHOLD, 8'd0));
        add_row(ev_row(FUNC_PERIOD_END, CODE_NONE, 1'b0, 1'b1, 1'b1, CODE_NONE));

        // Hold reset, then release it at a falling edge
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Walk the directed table without idling
        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.kind == ROW_WRITE)
            begin
                settle();
                write_reg(row.idx, row.data);
            end
            else
                send_event(row.ev, row.typed, row.status);
        end

        // Random phases: none, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++)
        begin
            settle();
            case (ph)
                0: thr_sel = 0;
                1: thr_sel = 255;
                2: thr_sel = $urandom_range(1, 6);
                default: thr_sel = $urandom_range(2, 12);
            endcase
            write_reg(REG_MISS_THRESHOLD, CFG_DAT_W'(thr_sel));
            write_reg(REG_NODE_IS_PRIMARY, (ph == 1) ? 8'd0 : (ph == 3) ?
                      CFG_DAT_W'($urandom_range(0, 1)) : 8'd1);
            send_idle_pct = (ph == 1) ? 87 : (ph == 3) ? 19 : 0;
            stall_pct    <= (ph == 2) ? 87 : (ph == 3) ? 19 : 0;
            burst_max     = (thr_sel + 3 > 20) ? 20 : thr_sel + 3;

            // Large threshold: one silence long enough to saturate the counter
            if (thr_sel == 255)
                repeat (258) send_item(FUNC_PERIOD_END, 2'($urandom), 1'($urandom));

            pick = events_sent + PHASE_ITEMS;
            while (events_sent < pick)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4:
                    begin
                        // single event with random fields, rare unused func
                        case ($urandom_range(0, 19))
                            0, 1, 2, 3, 4, 5, 6:       f = FUNC_HEARTBEAT;
                            7, 8, 9, 10, 11:           f = FUNC_SWITCH;
                            19:                        f = FUNC_UNUSED;
                            default:                   f = FUNC_PERIOD_END;
                        endcase
                        send_item(f, 2'($urandom), 1'($urandom));
                    end
                    5, 6:
                    begin
                        // switch exchange: request, a period, peer answer, a period
                        send_item(FUNC_SWITCH, 2'($urandom_range(1, 2)), 1'($urandom));
                        send_item(FUNC_PERIOD_END, 2'($urandom), 1'($urandom));
                        send_item(FUNC_HEARTBEAT,
                                  ($urandom_range(0, 3) != 0) ? CODE_ACK : CODE_NONE,
                                  1'($urandom));
                        send_item(FUNC_PERIOD_END, 2'($urandom), 1'($urandom));
                    end
                    7:
                    begin
                        // peer silent for a while, possibly past the threshold
                        repeat ($urandom_range(1, burst_max))
                            send_item(FUNC_PERIOD_END, 2'($urandom), 1'($urandom));
                    end
                    default:
                    begin
                        // peer-driven role order followed by a period
                        send_item(FUNC_HEARTBEAT, 2'($urandom_range(1, 2)), 1'($urandom));
                        send_item(FUNC_PERIOD_END, 2'($urandom), 1'($urandom));
                    end
                endcase
            end

            // Back-pressure: hold the receiver off and offer a run of period ends, so that
            // the block fills up and stalls its input
            if (ph == 0)
            begin
                hold_req <= 1'b1;
                repeat (PRESSURE_ITEMS)
                    send_item(FUNC_PERIOD_END, 2'($urandom), 1'($urandom));
            end
        end

        settle();
        $display("covered %0d events and %0d checked statuses, %0d register writes,",
                 events_sent, statuses_seen, reg_writes);
        $display("four idle/stall mixes and one %0d-cycle receiver hold-off", HOLD_CYCLES);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[filelist.f]
src/hsfo_pkg.sv
src/hsfo_cfg.sv
src/hsfo_core.sv
src/hot_standby_failover_controller.sv
src/hsfo_checker.sv
tb/sv/hot_standby_failover_controller_tb.sv
